>>> rtl/edst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EU summer time adjust package
// Shared item types, calendar constants and small helper functions.
// ----------------------------------------------------------------------------
package edst_pkg;

    // Direction of the one hour step
    typedef enum logic {
        MODE_TO_STANDARD = 1'b0,
        MODE_TO_LOCAL    = 1'b1
    } mode_t;

    // Calendar constants
    localparam logic [3:0] MONTH_MARCH     = 4'd3;
    localparam logic [3:0] MONTH_APRIL     = 4'd4;
    localparam logic [3:0] MONTH_JUNE      = 4'd6;
    localparam logic [3:0] MONTH_SEPTEMBER = 4'd9;
    localparam logic [3:0] MONTH_OCTOBER   = 4'd10;
    localparam logic [4:0] DAY_LONG        = 5'd31;
    localparam logic [4:0] DAY_SHORT       = 5'd30;
    localparam logic [4:0] DAY_FIRST       = 5'd1;
    localparam logic [4:0] HOUR_SWITCH     = 5'd2;
    localparam logic [4:0] HOUR_LAST       = 5'd23;
    localparam logic [2:0] WEEKDAY_FIRST   = 3'd1;
    localparam logic [2:0] WEEKDAY_LAST    = 3'd7;

    // Weekday offsets of the last Sunday formula
    localparam logic [7:0] OFFSET_MARCH    = 8'd5;
    localparam logic [7:0] OFFSET_OCTOBER  = 8'd2;

    // One input time
    typedef struct packed {
        mode_t      mode;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [2:0] weekday;
    } in_item_t;

    // One adjusted time
    typedef struct packed {
        logic       in_summer;
        logic [3:0] out_month;
        logic [4:0] out_day;
        logic [4:0] out_hour;
        logic [2:0] out_weekday;
    } out_item_t;

    // Remainder modulo 7 of an 8-bit value: fold by 64 and 8, then trim
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [6:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = {5'b0, x[7:6]} + {1'b0, x[5:0]};
        s2 = s1[6:3] + {1'b0, s1[2:0]};
        r  = s2;
        if (r >= 4'd7)
            r = r - 4'd7;
        if (r >= 4'd7)
            r = r - 4'd7;
        return r[2:0];
    endfunction

    // Number of days in a month
    function automatic logic [4:0] month_length(input logic [3:0] m);
        if (m == MONTH_APRIL || m == MONTH_JUNE || m == MONTH_SEPTEMBER)
            return DAY_SHORT;
        return DAY_LONG;
    endfunction

endpackage

>>> rtl/edst_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input time channel
// Valid/ready channel carrying one calendar time per transfer.
// ----------------------------------------------------------------------------
interface edst_in_if
    import edst_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/edst_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjusted time channel
// Valid/ready channel carrying one adjusted time per transfer.
// ----------------------------------------------------------------------------
interface edst_out_if
    import edst_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/edst_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the summer time enable bit.
// ----------------------------------------------------------------------------
interface edst_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/edst_summer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Summer period detector
// Finds the last Sundays of March and October and tests the input time.
// ----------------------------------------------------------------------------
module edst_summer
    import edst_pkg::*;
(
    input  logic     enable,
    input  in_item_t item,
    output logic     in_summer
);

    logic [7:0] base;
    logic [4:0] march_day;
    logic [4:0] october_day;
    logic       in_middle;
    logic       in_march;
    logic       in_october;

    // Last Sunday of March and October from the two-digit year
    always_comb
    begin
        base        = {1'b0, item.year} + {3'b0, item.year[6:2]};
        march_day   = DAY_LONG - {2'b0, mod7(base + OFFSET_MARCH)};
        october_day = DAY_LONG - {2'b0, mod7(base + OFFSET_OCTOBER)};
    end

    // Compare the time against the period bounds
    always_comb
    begin
        in_middle  = (item.month > MONTH_MARCH) && (item.month < MONTH_OCTOBER);
        in_march   = (item.month == MONTH_MARCH) &&
                     ((item.day > march_day) ||
                      ((item.day == march_day) && (item.hour >= HOUR_SWITCH)));
        in_october = (item.month == MONTH_OCTOBER) &&
                     ((item.day < october_day) ||
                      ((item.day == october_day) && (item.hour < HOUR_SWITCH)));
        in_summer  = enable && (in_middle || in_march || in_october);
    end

endmodule

>>> rtl/edst_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hour step with calendar rollover
// When in summer, moves the time one hour forward or back and rolls day, weekday, month.
// ----------------------------------------------------------------------------
module edst_adjust
    import edst_pkg::*;
(
    input  in_item_t  item,
    input  logic      in_summer,
    output out_item_t result
);

    logic [3:0] m;
    logic [4:0] d;
    logic [4:0] h;
    logic [2:0] w;
    logic [5:0] d_fwd;

    // Step the hour and carry into the date
    always_comb
    begin
        m     = item.month;
        d     = item.day;
        h     = item.hour;
        w     = item.weekday;
        d_fwd = {1'b0, item.day};
        if (in_summer)
        begin
            if (item.mode == MODE_TO_LOCAL)
            begin
                if (item.hour >= HOUR_LAST)
                begin
                    h     = 5'd0;
                    d_fwd = {1'b0, item.day} + 6'd1;
                    w = (item.weekday >= WEEKDAY_LAST) ? WEEKDAY_FIRST
                                                       : item.weekday + 3'd1;
                end
                else
                begin
                    h = item.hour + 5'd1;
                end
                // Keep the day one bit wider so day 31 plus one still rolls over
                if (d_fwd > {1'b0, month_length(item.month)})
                begin
                    m = item.month + 4'd1;
                    d = DAY_FIRST;
                end
                else
                begin
                    d = d_fwd[4:0];
                end
            end
            else
            begin
                if (item.hour == 5'd0)
                begin
                    h = HOUR_LAST;
                    d = (item.day == 5'd0) ? 5'd0 : item.day - 5'd1;
                    w = (item.weekday <= WEEKDAY_FIRST) ? WEEKDAY_LAST
                                                        : item.weekday - 3'd1;
                end
                else
                begin
                    h = item.hour - 5'd1;
                end
                if (d == 5'd0)
                begin
                    m = (item.month == 4'd0) ? 4'd0 : item.month - 4'd1;
                    d = month_length(m);
                end
            end
        end
    end

    // Pack the result
    always_comb
    begin
        result.in_summer   = in_summer;
        result.out_month   = m;
        result.out_day     = d;
        result.out_hour    = h;
        result.out_weekday = w;
    end

endmodule

>>> rtl/eu_dst_local_time_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EU summer time local time adjust
// Usage:
//   calendar  valid/ready channel, one time (mode, year, month, day, hour,
//             weekday) per transfer.
//   adjusted  valid/ready channel, one result (in_summer and the adjusted
//             month, day, hour, weekday) per input transfer, in order.
//   cfg       write channel for dst_enable, always ready; write it only
//             while no time is in flight.
//   Pipeline: the input register takes the time at its transfer, then the
//   result register takes the adjusted time, and the result is offered
//   from the result register. Throughput is one time per cycle while the
//   receiver takes results; each register advances when its side frees up.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more time; calendar.ready then drops until
//   the result is taken.
//   Reset clears both valid flags and dst_enable, so detection starts off
//   and every time passes through unchanged until enabled.
// ----------------------------------------------------------------------------
module eu_dst_local_time_adjust
    import edst_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    edst_in_if.sink         calendar,
    edst_out_if.source      adjusted,
    edst_cfg_if.sink        cfg
);

    logic      enable_reg;
    logic      stage_valid_reg;
    logic      stage_valid_next;
    in_item_t  stage_item_reg;
    logic      result_valid_reg;
    logic      result_valid_next;
    out_item_t result_item_reg;
    logic      result_load;
    logic      stage_load;
    logic      summer;
    out_item_t result_item_next;

    // Configuration is always taken
    assign cfg.ready = 1'b1;

    // Advance each register when its downstream side frees up
    assign result_load       = !result_valid_reg || adjusted.ready;
    assign stage_load        = !stage_valid_reg || result_load;
    assign calendar.ready    = stage_load;
    assign stage_valid_next  = stage_load ? calendar.valid : stage_valid_reg;
    assign result_valid_next = result_load ? stage_valid_reg : result_valid_reg;

    // Hold the enable bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b0;
        else if (cfg.valid && cfg.ready)
            enable_reg <= cfg.data;
    end

    // Track valid flags of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Capture the input time on transfer
    always_ff @(posedge clk)
    begin
        if (stage_load && calendar.valid)
            stage_item_reg <= calendar.data;
    end

    edst_summer u_summer (
        .enable    (enable_reg),
        .item      (stage_item_reg),
        .in_summer (summer)
    );

    edst_adjust u_adjust (
        .item      (stage_item_reg),
        .in_summer (summer),
        .result    (result_item_next)
    );

    // Capture the adjusted time
    always_ff @(posedge clk)
    begin
        if (result_load && stage_valid_reg)
            result_item_reg <= result_item_next;
    end

    assign adjusted.valid = result_valid_reg;
    assign adjusted.data  = result_item_reg;

endmodule
